FILE: rtl/pcol_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcol_pkg
// Shared widths and helpers for the particle pair collision block.
// ----------------------------------------------------------------------------
package pcol_pkg;

    // item field widths
    localparam int DATA_W  = 32;
    localparam int RAD_W   = 24;

    // shared multiplier operand and product widths
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 64;

    // divider denominator width
    localparam int DEN_W   = 34;

    // any difference at or beyond this power of two cannot collide
    localparam int FAR_EXP = 25;
    // clamp exponent for the back-off time
    localparam int BT_EXP  = 30;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > 64'sh000000007fffffff)
            r = 32'sh7fffffff;
        else if (x < -64'sh0000000080000000)
            r = 32'sh80000000;
        else
            r = x[DATA_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/particle_pair_collision.sv
`default_nettype none
// ----------------------------------------------------------------------------
// particle_pair_collision
// Sphere pair collision response with restitution 0.9 in fixed point.
// ----------------------------------------------------------------------------
// first item of a pair: accepted, held, no result
// second item: the work is set by the bit-serial divider for the three normal
// components and the back-off time, and by the 27-step root; far-apart pairs
// finish after the difference step, out of reach after the squared-radius check,
// not closing after the closing speed check
// input is not ready until both results leave; rst_n is asynchronous, active low
// ----------------------------------------------------------------------------
module particle_pair_collision #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius
    input  wire logic [215:0]  s_axis_tdata,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
    output logic [191:0]       m_axis_tdata,
    // collided
    output logic               m_axis_tuser,
    output logic               m_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    input  wire logic          cfg_wr_en,
    input  wire logic [23:0]   cfg_wr_data
);

    localparam int DW    = pcol_pkg::DATA_W;
    localparam int MW    = pcol_pkg::MUL_W;
    localparam int PW    = pcol_pkg::PROD_W;
    localparam int DIV_W = FRAC_BITS + 28;
    localparam logic signed [MW-1:0] K_MUL = MW'((9 * (1 << FRAC_BITS) + 5) / 10);
    localparam logic [53:0] SQ_TOP = 54'(1) << 52;
    localparam logic signed [32:0] FAR_LIM = 33'sd1 <<< pcol_pkg::FAR_EXP;
    localparam logic [DIV_W-1:0] BT_LIM = DIV_W'(1) << pcol_pkg::BT_EXP;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_MAC, S_SQRT, S_NDIV_GO, S_NDIV_WAIT,
        S_CCHK, S_BT_GO, S_BT_WAIT, S_UPD, S_OUT1, S_OUT2
    } state_t;

    typedef enum logic [3:0] {
        OP_DSQ, OP_RSQ, OP_DN, OP_V1, OP_V2, OP_M1, OP_M2, OP_K1, OP_K2
    } op_t;

    state_t state_reg;
    op_t    op_reg;
    logic   phase_reg;
    logic   hit_reg;
    logic [pcol_pkg::RAD_W-1:0] step_time_reg;

    logic signed [DW-1:0] p1_reg [3];
    logic signed [DW-1:0] u1_reg [3];
    logic signed [DW-1:0] p2_reg [3];
    logic signed [DW-1:0] u2_reg [3];
    logic [pcol_pkg::RAD_W-1:0] r1_reg;
    logic [pcol_pkg::RAD_W-1:0] r2_reg;

    logic signed [MW-1:0] d_reg [3];
    logic signed [MW-1:0] n_reg [3];
    logic [24:0]          rs_reg;
    logic [52:0]          dist2_reg;
    logic [52:0]          sq_v_reg;
    logic [53:0]          sq_r_reg;
    logic [53:0]          sq_bit_reg;
    logic [26:0]          dist_reg;
    logic signed [MW-1:0] dn_reg;
    logic signed [DW-1:0] v1_reg;
    logic signed [DW-1:0] v2_reg;
    logic signed [DW-1:0] bt_reg;
    logic signed [DW-1:0] m1_reg;
    logic signed [DW-1:0] m2_reg;
    logic signed [MW-1:0] dv1_reg;
    logic signed [MW-1:0] dv2_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [PW-1:0] prod_reg;
    logic [1:0]           cnt_reg;
    logic [1:0]           idx_reg;
    logic [1:0]           grp_reg;
    logic                 iss_reg;
    logic                 wb_vld_reg;
    logic [1:0]           wb_grp_reg;
    logic [1:0]           wb_idx_reg;
    logic                 div_start_reg;

    logic signed [DW-1:0] in_pos [3];
    logic signed [DW-1:0] in_vel [3];
    logic signed [32:0]   diff [3];
    logic                 far_any;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [2*MW-1:0] prod_full;
    logic signed [PW-1:0] mac_sum;
    logic signed [PW-1:0] mac_shr;
    logic signed [MW-1:0] dt_s;
    logic signed [MW-1:0] dt_bt;
    logic [53:0]          sq_sum;
    logic                 sq_ge;
    logic [53:0]          sq_r_nx;
    logic signed [MW-1:0] d_sel;
    logic signed [MW-1:0] d_mag;
    logic signed [MW-1:0] e_val;
    logic signed [MW-1:0] e_mag;
    logic signed [32:0]   c_val;
    logic [DIV_W-1:0]     div_num;
    logic [pcol_pkg::DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quo;
    logic signed [MW-1:0] n_new;
    logic [DW-1:0]        bt_mag;
    logic signed [DW-1:0] bt_val;
    logic signed [PW-1:0] wb_shr;
    logic signed [DW-1:0] wb_old;
    logic signed [DW-1:0] wb_new;

    // input item fields
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_pos[i] = s_axis_tdata[32*i +: 32];
            in_vel[i] = s_axis_tdata[96 + 32*i +: 32];
        end
    end

    // centre differences and far check
    always_comb
    begin
        far_any = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = 33'(p2_reg[i]) - 33'(p1_reg[i]);
            if (diff[i] >= FAR_LIM || diff[i] <= -FAR_LIM)
                far_any = 1'b1;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        dt_s  = $signed(MW'(step_time_reg));
        dt_bt = dt_s - MW'(bt_reg);
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_MAC && cnt_reg != 2'd3)
        begin
            case (op_reg)
                OP_DSQ:
                begin
                    mul_a = d_reg[cnt_reg];
                    mul_b = d_reg[cnt_reg];
                end
                OP_RSQ:
                begin
                    mul_a = (cnt_reg == 2'd0) ? $signed(MW'(rs_reg)) : '0;
                    mul_b = $signed(MW'(rs_reg));
                end
                OP_DN:
                begin
                    mul_a = d_reg[cnt_reg];
                    mul_b = n_reg[cnt_reg];
                end
                OP_V1:
                begin
                    mul_a = MW'(u1_reg[cnt_reg]);
                    mul_b = n_reg[cnt_reg];
                end
                OP_V2:
                begin
                    mul_a = MW'(u2_reg[cnt_reg]);
                    mul_b = n_reg[cnt_reg];
                end
                OP_M1:
                begin
                    mul_a = (cnt_reg == 2'd0) ? -MW'(v1_reg) :
                            (cnt_reg == 2'd1) ? dt_bt : '0;
                    mul_b = (cnt_reg == 2'd0) ? MW'(bt_reg) : MW'(v2_reg);
                end
                OP_M2:
                begin
                    mul_a = (cnt_reg == 2'd0) ? -MW'(v2_reg) :
                            (cnt_reg == 2'd1) ? dt_bt : '0;
                    mul_b = (cnt_reg == 2'd0) ? MW'(bt_reg) : MW'(v1_reg);
                end
                OP_K1:
                begin
                    mul_a = (cnt_reg == 2'd0) ? K_MUL : '0;
                    mul_b = MW'(v2_reg);
                end
                OP_K2:
                begin
                    mul_a = (cnt_reg == 2'd0) ? K_MUL : '0;
                    mul_b = MW'(v1_reg);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        else if (state_reg == S_UPD && iss_reg)
        begin
            case (grp_reg)
                2'd0:    mul_a = MW'(m1_reg);
                2'd1:    mul_a = MW'(m2_reg);
                2'd2:    mul_a = dv1_reg;
                default: mul_a = dv2_reg;
            endcase
            mul_b = n_reg[idx_reg];
        end
    end

    assign prod_full = mul_a * mul_b;
    assign mac_sum   = acc_reg + prod_reg;
    assign mac_shr   = mac_sum >>> FRAC_BITS;

    // one step of the integer square root
    always_comb
    begin
        sq_sum  = sq_r_reg + sq_bit_reg;
        sq_ge   = ({1'b0, sq_v_reg} >= sq_sum);
        sq_r_nx = sq_ge ? ((sq_r_reg >> 1) + sq_bit_reg) : (sq_r_reg >> 1);
    end

    // divider operands and result shaping
    always_comb
    begin
        d_sel = d_reg[idx_reg];
        d_mag = d_sel[MW-1] ? -d_sel : d_sel;
        e_val = $signed(MW'(rs_reg)) - dn_reg;
        e_mag = e_val[MW-1] ? -e_val : e_val;
        c_val = 33'(v1_reg) - 33'(v2_reg);
        if (state_reg == S_NDIV_GO || state_reg == S_NDIV_WAIT)
        begin
            div_num = DIV_W'($unsigned(d_mag)) << FRAC_BITS;
            div_den = pcol_pkg::DEN_W'(dist_reg);
        end
        else
        begin
            div_num = DIV_W'($unsigned(e_mag)) << FRAC_BITS;
            div_den = pcol_pkg::DEN_W'($unsigned(c_val));
        end
        n_new  = d_sel[MW-1] ? -$signed(MW'(div_quo)) : $signed(MW'(div_quo));
        bt_mag = (div_quo > BT_LIM) ? DW'(BT_LIM) : div_quo[DW-1:0];
        bt_val = e_val[MW-1] ? -$signed(bt_mag) : $signed(bt_mag);
    end

    // position and velocity writeback
    always_comb
    begin
        wb_shr = prod_reg >>> FRAC_BITS;
        case (wb_grp_reg)
            2'd0:    wb_old = p1_reg[wb_idx_reg];
            2'd1:    wb_old = p2_reg[wb_idx_reg];
            2'd2:    wb_old = u1_reg[wb_idx_reg];
            default: wb_old = u2_reg[wb_idx_reg];
        endcase
        wb_new = pcol_pkg::sat32(PW'(wb_old) + wb_shr);
    end

    pcol_div #(
        .NUM_W (DIV_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_DSQ;
            phase_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            step_time_reg <= 24'd655;
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= '0;
                u1_reg[i] <= '0;
                p2_reg[i] <= '0;
                u2_reg[i] <= '0;
                d_reg[i]  <= '0;
                n_reg[i]  <= '0;
            end
            r1_reg        <= '0;
            r2_reg        <= '0;
            rs_reg        <= '0;
            dist2_reg     <= '0;
            sq_v_reg      <= '0;
            sq_r_reg      <= '0;
            sq_bit_reg    <= '0;
            dist_reg      <= '0;
            dn_reg        <= '0;
            v1_reg        <= '0;
            v2_reg        <= '0;
            bt_reg        <= '0;
            m1_reg        <= '0;
            m2_reg        <= '0;
            dv1_reg       <= '0;
            dv2_reg       <= '0;
            acc_reg       <= '0;
            prod_reg      <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            grp_reg       <= '0;
            iss_reg       <= 1'b0;
            wb_vld_reg    <= 1'b0;
            wb_grp_reg    <= '0;
            wb_idx_reg    <= '0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (cfg_wr_en)
                step_time_reg <= cfg_wr_data;

            case (state_reg)
                // take items; the first of a pair is only held
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        if (!phase_reg)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                p1_reg[i] <= in_pos[i];
                                u1_reg[i] <= in_vel[i];
                            end
                            r1_reg    <= s_axis_tdata[215:192];
                            phase_reg <= 1'b1;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                p2_reg[i] <= in_pos[i];
                                u2_reg[i] <= in_vel[i];
                            end
                            r2_reg    <= s_axis_tdata[215:192];
                            phase_reg <= 1'b0;
                            state_reg <= S_DIFF;
                        end
                    end
                end

                // differences and radius sum
                S_DIFF:
                begin
                    for (int i = 0; i < 3; i++)
                        d_reg[i] <= MW'(diff[i]);
                    rs_reg  <= 25'(r1_reg) + 25'(r2_reg);
                    hit_reg <= 1'b0;
                    if (far_any)
                        state_reg <= S_OUT1;
                    else
                    begin
                        op_reg    <= OP_DSQ;
                        cnt_reg   <= '0;
                        state_reg <= S_MAC;
                    end
                end

                // three-term multiply-accumulate on the shared multiplier
                S_MAC:
                begin
                    if (cnt_reg != 2'd3)
                        prod_reg <= prod_full[PW-1:0];
                    acc_reg <= (cnt_reg == 2'd0) ? '0 : mac_sum;
                    // counter wraps from three back to zero
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 2'd3)
                    begin
                        case (op_reg)
                            OP_DSQ:
                            begin
                                dist2_reg <= mac_sum[52:0];
                                op_reg    <= OP_RSQ;
                            end
                            OP_RSQ:
                            begin
                                if (dist2_reg == '0 || PW'(dist2_reg) >= mac_sum)
                                    state_reg <= S_OUT1;
                                else
                                begin
                                    sq_v_reg   <= dist2_reg;
                                    sq_r_reg   <= '0;
                                    sq_bit_reg <= SQ_TOP;
                                    state_reg  <= S_SQRT;
                                end
                            end
                            OP_DN:
                            begin
                                dn_reg <= MW'(mac_shr);
                                op_reg <= OP_V1;
                            end
                            OP_V1:
                            begin
                                v1_reg <= pcol_pkg::sat32(mac_shr);
                                op_reg <= OP_V2;
                            end
                            OP_V2:
                            begin
                                v2_reg    <= pcol_pkg::sat32(mac_shr);
                                state_reg <= S_CCHK;
                            end
                            OP_M1:
                            begin
                                m1_reg <= pcol_pkg::sat32(mac_shr);
                                op_reg <= OP_M2;
                            end
                            OP_M2:
                            begin
                                m2_reg <= pcol_pkg::sat32(mac_shr);
                                op_reg <= OP_K1;
                            end
                            OP_K1:
                            begin
                                dv1_reg <= MW'(mac_shr) - MW'(v1_reg);
                                op_reg  <= OP_K2;
                            end
                            OP_K2:
                            begin
                                dv2_reg    <= MW'(mac_shr) - MW'(v2_reg);
                                iss_reg    <= 1'b1;
                                grp_reg    <= '0;
                                idx_reg    <= '0;
                                wb_vld_reg <= 1'b0;
                                state_reg  <= S_UPD;
                            end
                            default:
                                state_reg <= S_OUT1;
                        endcase
                    end
                end

                // root of the squared distance, two bits a step
                S_SQRT:
                begin
                    if (sq_ge)
                        sq_v_reg <= sq_v_reg - sq_sum[52:0];
                    sq_r_reg   <= sq_r_nx;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0])
                    begin
                        dist_reg  <= sq_r_nx[26:0];
                        idx_reg   <= '0;
                        state_reg <= S_NDIV_GO;
                    end
                end

                // unit normal components
                S_NDIV_GO:
                begin
                    div_start_reg <= 1'b1;
                    state_reg     <= S_NDIV_WAIT;
                end

                S_NDIV_WAIT:
                begin
                    if (div_done)
                    begin
                        n_reg[idx_reg] <= n_new;
                        if (idx_reg == 2'd2)
                        begin
                            op_reg    <= OP_DN;
                            cnt_reg   <= '0;
                            state_reg <= S_MAC;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_NDIV_GO;
                        end
                    end
                end

                // closing speed check
                S_CCHK:
                begin
                    if (c_val <= 33'sd0)
                        state_reg <= S_OUT1;
                    else
                        state_reg <= S_BT_GO;
                end

                // back-off time
                S_BT_GO:
                begin
                    div_start_reg <= 1'b1;
                    state_reg     <= S_BT_WAIT;
                end

                S_BT_WAIT:
                begin
                    if (div_done)
                    begin
                        bt_reg    <= bt_val;
                        op_reg    <= OP_M1;
                        cnt_reg   <= '0;
                        state_reg <= S_MAC;
                    end
                end

                // twelve scaled normal updates, one product a cycle
                S_UPD:
                begin
                    wb_vld_reg <= iss_reg;
                    if (iss_reg)
                    begin
                        prod_reg   <= prod_full[PW-1:0];
                        wb_grp_reg <= grp_reg;
                        wb_idx_reg <= idx_reg;
                        if (idx_reg == 2'd2)
                        begin
                            idx_reg <= '0;
                            grp_reg <= grp_reg + 1'b1;
                            if (grp_reg == 2'd3)
                                iss_reg <= 1'b0;
                        end
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                    if (wb_vld_reg)
                    begin
                        case (wb_grp_reg)
                            2'd0:    p1_reg[wb_idx_reg] <= wb_new;
                            2'd1:    p2_reg[wb_idx_reg] <= wb_new;
                            2'd2:    u1_reg[wb_idx_reg] <= wb_new;
                            default: u2_reg[wb_idx_reg] <= wb_new;
                        endcase
                    end
                    if (!iss_reg && wb_vld_reg)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_OUT1;
                    end
                end

                // two result items, first particle then second
                S_OUT1:
                begin
                    if (m_axis_tready)
                        state_reg <= S_OUT2;
                end

                S_OUT2:
                begin
                    if (m_axis_tready)
                        state_reg <= S_IDLE;
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // handshake and result item
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT1) || (state_reg == S_OUT2);
    assign m_axis_tlast  = (state_reg == S_OUT2);
    assign m_axis_tuser  = hit_reg;
    assign m_axis_tdata  = (state_reg == S_OUT2) ?
        {u2_reg[2], u2_reg[1], u2_reg[0], p2_reg[2], p2_reg[1], p2_reg[0]} :
        {u1_reg[2], u1_reg[1], u1_reg[0], p1_reg[2], p1_reg[1], p1_reg[0]};

    // never taking an item while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted during output");

    // results only once a full pair is in
    a_pair_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !phase_reg)
        else $error("result with half a pair held");

    // divider results land only where they are awaited
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_NDIV_WAIT || state_reg == S_BT_WAIT))
        else $error("divider result not awaited");

endmodule
`default_nettype wire

FILE: rtl/pcol_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcol_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcol_div #(
    parameter int NUM_W = 44
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [NUM_W-1:0]            num,
    input  wire logic [pcol_pkg::DEN_W-1:0]  den,
    output logic                             done,
    output logic [NUM_W-1:0]                 quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [pcol_pkg::DEN_W-1:0]  rem_reg;
    logic [pcol_pkg::DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]            shf_reg;

    logic [pcol_pkg::DEN_W:0]    trial;
    logic [pcol_pkg::DEN_W:0]    diff;
    logic                        ge;

    // trial subtract of the next partial remainder
    always_comb
    begin
        trial = {rem_reg, shf_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    // iteration control and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            shf_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                rem_reg  <= '0;
                den_reg  <= den;
                shf_reg  <= num;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[pcol_pkg::DEN_W-1:0] : trial[pcol_pkg::DEN_W-1:0];
                shf_reg <= {shf_reg[NUM_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = shf_reg;

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && den_reg != '0) |-> (rem_reg < den_reg))
        else $error("divider remainder out of range");

    // done only at the end of a run
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a run");

    // a start always begins a run
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");

endmodule
`default_nettype wire

FILE: dv/particle_pair_collision_test.sv
// ----------------------------------------------------------------------------
// particle_pair_collision_test
// Self-checking bench for the particle pair collision block. Particle items
// are sent in pairs over the input stream. A local fixed-point model of the
// collision response predicts both result items of each pair, and the
// checker compares every result field with the oldest prediction. Both
// stream sides idle at random, and the step time is changed between phases.
// ----------------------------------------------------------------------------
module particle_pair_collision_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC      = 16;
    localparam longint ONE       = longint'(1) << FRAC;
    localparam longint FAR_LIM   = longint'(1) << pcol_pkg::FAR_EXP;
    localparam longint CLAMP_LIM = longint'(1) << pcol_pkg::BT_EXP;
    localparam int     DRAIN     = 400;

    typedef struct {
        logic signed [31:0] p [3];
        logic signed [31:0] v [3];
        logic [23:0]        r;
    } particle_t;

    typedef struct {
        logic signed [31:0] p [3];
        logic signed [31:0] v [3];
        logic               hit;
        logic               last;
    } outcome_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic [215:0]   s_axis_tdata = '0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [191:0]   m_axis_tdata;
    logic           m_axis_tuser;
    logic           m_axis_tlast;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic           cfg_wr_en = 1'b0;
    logic [23:0]    cfg_wr_data = '0;

    // model state
    longint     step_dt = 655;
    particle_t  held_particle;
    bit         pair_open = 1'b0;
    outcome_t   pending_outcomes [$];

    int  errors = 0;
    bit  no_idle = 1'b0;
    int  stall_left = 0;

    particle_pair_collision #(.FRAC_BITS(FRAC)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // floor of x / 2^F
    function automatic longint fshr(longint x);
        return x >>> FRAC;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000000000000000;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // collision response of one pair; returns 1 when applied
    function automatic bit resolve_pair(inout longint p1 [3], inout longint u1 [3],
                                        input longint r1, inout longint p2 [3],
                                        inout longint u2 [3], input longint r2);
        longint d [3];
        longint n [3];
        longint rs, center_dist, dn, v1, v2, c, bt, m1, m2, k, dv1, dv2;
        longint dist2;
        rs = r1 + r2;
        dist2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = p2[i] - p1[i];
            if (d[i] >= FAR_LIM || d[i] <= -FAR_LIM)
                return 1'b0;
            dist2 += d[i] * d[i];
        end
        if (dist2 == 0 || dist2 >= rs * rs)
            return 1'b0;
        center_dist = longint'(root_floor(dist2));
        if (center_dist < 1)
            return 1'b0;
        for (int i = 0; i < 3; i++)
            n[i] = (d[i] * ONE) / center_dist;
        dn = 0;
        v1 = 0;
        v2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            dn += d[i] * n[i];
            v1 += u1[i] * n[i];
            v2 += u2[i] * n[i];
        end
        dn = fshr(dn);
        v1 = clamp32(fshr(v1));
        v2 = clamp32(fshr(v2));
        c = v1 - v2;
        if (c <= 0)
            return 1'b0;
        bt = ((rs - dn) * ONE) / c;
        if (bt > CLAMP_LIM)
            bt = CLAMP_LIM;
        if (bt < -CLAMP_LIM)
            bt = -CLAMP_LIM;
        m1 = clamp32(fshr(-v1 * bt + (step_dt - bt) * v2));
        m2 = clamp32(fshr(-v2 * bt + (step_dt - bt) * v1));
        k = (9 * ONE + 5) / 10;
        dv1 = fshr(k * v2) - v1;
        dv2 = fshr(k * v1) - v2;
        for (int i = 0; i < 3; i++)
        begin
            p1[i] = clamp32(p1[i] + fshr(m1 * n[i]));
            p2[i] = clamp32(p2[i] + fshr(m2 * n[i]));
            u1[i] = clamp32(u1[i] + fshr(dv1 * n[i]));
            u2[i] = clamp32(u2[i] + fshr(dv2 * n[i]));
        end
        return 1'b1;
    endfunction

    // hold the first particle, or predict both results on the second
    task automatic predict_collision(input particle_t q);
        longint p1 [3], u1 [3], p2 [3], u2 [3];
        bit hit;
        outcome_t o1, o2;
        if (!pair_open)
        begin
            held_particle = q;
            pair_open = 1'b1;
            return;
        end
        pair_open = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            p1[i] = held_particle.p[i];
            u1[i] = held_particle.v[i];
            p2[i] = q.p[i];
            u2[i] = q.v[i];
        end
        hit = resolve_pair(p1, u1, held_particle.r, p2, u2, q.r);
        for (int i = 0; i < 3; i++)
        begin
            o1.p[i] = p1[i][31:0];
            o1.v[i] = u1[i][31:0];
            o2.p[i] = p2[i][31:0];
            o2.v[i] = u2[i][31:0];
        end
        o1.hit = hit;
        o2.hit = hit;
        o1.last = 1'b0;
        o2.last = 1'b1;
        pending_outcomes.push_back(o1);
        pending_outcomes.push_back(o2);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        outcome_t w;
        logic [31:0] word;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t result item with no prediction", $realtime);
                errors++;
            end
            else
            begin
                w = pending_outcomes.pop_front();
                for (int i = 0; i < 3; i++)
                begin
                    word = m_axis_tdata[32*i +: 32];
                    if (word !== w.p[i])
                        report_mismatch($sformatf("new_pos[%0d]", i), word, w.p[i]);
                    word = m_axis_tdata[96 + 32*i +: 32];
                    if (word !== w.v[i])
                        report_mismatch($sformatf("new_vel[%0d]", i), word, w.v[i]);
                end
                if (m_axis_tuser !== w.hit)
                    report_mismatch("collided", 32'(m_axis_tuser), 32'(w.hit));
                if (m_axis_tlast !== w.last)
                    report_mismatch("last_of_pair", 32'(m_axis_tlast), 32'(w.last));
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        int r;
        if (stall_left > 0)
        begin
            m_axis_tready = 1'b0;
            stall_left--;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (no_idle || r < 70)
                m_axis_tready = 1'b1;
            else
            begin
                m_axis_tready = 1'b0;
                stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_particle(input particle_t q);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tdata = {q.r, q.v[2], q.v[1], q.v[0], q.p[2], q.p[1], q.p[0]};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_collision(q);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_step_time(input logic [23:0] value);
        wait_drained();
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        cfg_wr_data = 24'($urandom);
        step_dt = value;
    endtask

    function automatic longint srand(longint lim);
        return longint'($urandom_range(0, 32'(2 * lim))) - lim;
    endfunction

    function automatic particle_t make_particle(longint p0, longint p1, longint p2,
                                                longint v0, longint v1, longint v2,
                                                longint r);
        particle_t q;
        q.p[0] = p0[31:0];
        q.p[1] = p1[31:0];
        q.p[2] = p2[31:0];
        q.v[0] = v0[31:0];
        q.v[1] = v1[31:0];
        q.v[2] = v2[31:0];
        q.r = r[23:0];
        return q;
    endfunction

    // one pair: mostly overlapping and closing, some wild, some fully random
    task automatic send_random_pair();
        particle_t a, b;
        longint r1, r2, rs, d [3], base [3], s1, s2;
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 15)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a.p[i] = $urandom;
                a.v[i] = $urandom;
                b.p[i] = $urandom;
                b.v[i] = $urandom;
            end
            a.r = 24'($urandom);
            b.r = 24'($urandom);
        end
        else
        begin
            r1 = $urandom_range(1 << 10, 1 << 22);
            r2 = $urandom_range(0, 1 << 22);
            rs = r1 + r2;
            s1 = $urandom_range(0, 4);
            s2 = $urandom_range(0, 4);
            for (int i = 0; i < 3; i++)
            begin
                d[i] = srand(rs / 2);
                base[i] = (mode < 25) ? longint'($signed($urandom)) : srand(1 << 28);
            end
            a = make_particle(base[0], base[1], base[2],
                              d[0] * s1 + srand(1 << 16), d[1] * s1 + srand(1 << 16),
                              d[2] * s1 + srand(1 << 16), r1);
            b = make_particle(base[0] + d[0], base[1] + d[1], base[2] + d[2],
                              -d[0] * s2 + srand(1 << 16), -d[1] * s2 + srand(1 << 16),
                              -d[2] * s2 + srand(1 << 16), r2);
            if (mode >= 90)
                for (int i = 0; i < 3; i++)
                begin
                    a.v[i] = $urandom;
                    b.v[i] = $urandom;
                end
        end
        send_particle(a);
        send_particle(b);
    endtask

    task automatic send_pair(input particle_t a, input particle_t b);
        send_particle(a);
        send_particle(b);
    endtask

    // corner pairs: each response path and the field extremes
    task automatic test_directed();
        longint u, mx, mn;
        u = ONE;
        mx = 64'sd2147483647;
        mn = -64'sd2147483648;
        no_idle = 1'b1;
        // head-on overlap
        send_pair(make_particle(0, 0, 0, u, 0, 0, u), make_particle(u, 0, 0, -u, 0, 0, u));
        // far apart along x
        send_pair(make_particle(0, 0, 0, u, 0, 0, 24'hffffff),
                  make_particle(FAR_LIM, 0, 0, -u, 0, 0, 24'hffffff));
        no_idle = 1'b0;
        // coincident centres
        send_pair(make_particle(5, 6, 7, u, 0, 0, u), make_particle(5, 6, 7, -u, 0, 0, u));
        // overlapping but moving apart
        send_pair(make_particle(0, 0, 0, -u, 0, 0, u), make_particle(u, 0, 0, u, 0, 0, u));
        // overlapping, zero closing speed
        send_pair(make_particle(0, 0, 0, u, u, 0, u), make_particle(0, u, 0, u, u, 0, u));
        // all-high against all-low fields
        send_pair(make_particle(mx, mx, mx, mx, mx, mx, 24'hffffff),
                  make_particle(mn, mn, mn, mn, mn, mn, 0));
        // identical extreme particles
        send_pair(make_particle(mx, mx, mx, mx, mx, mx, 24'hffffff),
                  make_particle(mx, mx, mx, mx, mx, mx, 24'hffffff));
        // zero radii, tiny offset
        send_pair(make_particle(0, 0, 0, u, 0, 0, 0), make_particle(1, 0, 0, -u, 0, 0, 0));
        // overlap next to the positive position limit, strong speeds
        send_pair(make_particle(mx - u, mx - u, mx - u, mx, mx, mx, 24'hffffff),
                  make_particle(mx, mx, mx, mn, mn, mn, 24'hffffff));
        // overlap next to the negative limit, diagonal
        send_pair(make_particle(mn, mn, mn, mx, 0, mx, 24'h800000),
                  make_particle(mn + u, mn + 3, mn + u, mn, 0, mn, 24'h800000));
    endtask

    task automatic test_random_phase(input int pairs);
        for (int i = 0; i < pairs; i++)
        begin
            no_idle = (i % 60) >= 50;
            send_random_pair();
        end
        no_idle = 1'b0;
    endtask

    // sender holds off until every result is back, at pair and mid-pair points
    task automatic test_drain_pause();
        particle_t a;
        for (int i = 0; i < 20; i++)
        begin
            send_random_pair();
            if (i % 5 == 0)
                wait_drained();
        end
        a = make_particle(0, 0, 0, ONE, 0, 0, ONE);
        send_particle(a);
        wait_drained();
        send_particle(make_particle(ONE / 2, 0, 0, -ONE, 0, 0, ONE));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_phase(120);
        set_step_time(24'd0);
        test_random_phase(120);
        set_step_time(24'hffffff);
        test_random_phase(120);
        set_step_time(24'(ONE));
        test_drain_pause();
        set_step_time(24'($urandom));
        test_random_phase(120);
        set_step_time(24'd655);
        test_random_phase(120);
        wait_drained();
        if (errors == 0 && pending_outcomes.size() == 0)
            $display("[particle_pair_collision] OK");
        else
            $display("[particle_pair_collision] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[particle_pair_collision] ERROR");
        $finish;
    end

endmodule
